// ===== rtl/core/integer_radix_formatter_macros.svh =====
// assertion macros shared by the integer radix formatter rtl
`ifndef INTEGER_RADIX_FORMATTER_MACROS_SVH
`define INTEGER_RADIX_FORMATTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/irf_pkg.sv =====
// shared constants and types for the integer radix formatter
package irf_pkg;

  localparam int MaxDigits    = 63;
  localparam int AlphabetSize = 64;
  localparam int RadixMin     = 2;

  localparam int ValueW  = 64;
  localparam int DigitW  = $clog2(AlphabetSize);      // one digit index
  localparam int RadixW  = $clog2(AlphabetSize + 1);  // divisor up to AlphabetSize
  localparam int CountW  = $clog2(ValueW + 1);        // natural count up to ValueW
  localparam int DbufAw  = $clog2(MaxDigits);
  localparam int CharW   = 8;
  localparam int FieldW  = 8;

  // divider retires this many quotient bits per cycle
  localparam int StepBits = 8;
  localparam int Steps    = ValueW / StepBits;
  localparam int StepCntW = $clog2(Steps);

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_UNSIGNED = 2'd1;
  localparam logic [1:0] CMD_SIGNED   = 2'd2;

  localparam logic [CharW-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_NONE  = 8'h00;

endpackage

// ===== rtl/core/irf_ram.sv =====
// generic single-write, single-read ram with registered read data
module irf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/irf_divider.sv =====
// multi-cycle divider of a 64-bit value by a small radix, several quotient bits per cycle
module irf_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [irf_pkg::ValueW-1:0]   dividend,
  input  logic [irf_pkg::RadixW-1:0]   divisor,
  output logic                         busy,
  output logic                         done,
  output logic [irf_pkg::ValueW-1:0]   quotient,
  output logic [irf_pkg::DigitW-1:0]   remainder
);

  logic [irf_pkg::ValueW-1:0]   shift_r, shift_nxt;
  logic [irf_pkg::DigitW-1:0]   rem_r, rem_nxt;
  logic [irf_pkg::RadixW-1:0]   div_r;
  logic [irf_pkg::StepCntW-1:0] cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [irf_pkg::StepBits-1:0] qbits;

  // restoring division over the top bits of the shift register
  always_comb begin
    logic [irf_pkg::DigitW:0] trial;
    rem_nxt = rem_r;
    qbits   = '0;
    for (int j = 0; j < irf_pkg::StepBits; j++) begin
      trial = {rem_nxt, shift_r[irf_pkg::ValueW-1-j]};
      if (trial >= div_r) begin
        trial = trial - div_r;
        qbits[irf_pkg::StepBits-1-j] = 1'b1;
      end
      rem_nxt = trial[irf_pkg::DigitW-1:0];
    end
    shift_nxt = {shift_r[irf_pkg::ValueW-irf_pkg::StepBits-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == irf_pkg::StepCntW'(irf_pkg::Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      shift_r <= dividend;
      rem_r   <= '0;
      div_r   <= divisor;
    end else if (busy_r) begin
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = shift_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/core/integer_radix_formatter.sv =====
// integer radix formatter: turns a 64-bit value into digit characters from a loaded alphabet.
// A load transaction writes one alphabet symbol. A format transaction divides the value by the radix
// until it reaches zero; every digit passes through the shared divider, which retires
// 8 quotient bits per cycle and yields one digit per division; a value has up to 64
// natural digits. The count is then settled in the sizing state, a signed transaction sends
// its sign after that, and each emitted character passes through digit buffer read, alphabet
// read and output load while the result side keeps up. A rejected radix loads a single error
// transaction into the output register once that register is free. The block takes no
// new transaction until the last character of the current one sits in the output register.
`include "integer_radix_formatter_macros.svh"

module integer_radix_formatter (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [irf_pkg::RadixW-1:0]         cfg_alphabet_length,
  // input transactions
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_cmd,
  input  logic [irf_pkg::ValueW-1:0]         in_number,
  input  logic [irf_pkg::DigitW-1:0]         in_symbol_index,
  input  logic [irf_pkg::CharW-1:0]          in_symbol_char,
  input  logic [irf_pkg::FieldW-1:0]         in_radix,
  input  logic [irf_pkg::FieldW-1:0]         in_least_digits,
  input  logic [irf_pkg::FieldW-1:0]         in_most_digits,
  // result transactions
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [irf_pkg::CharW-1:0]          out_char,
  output logic                               out_is_last,
  output logic                               out_bad_radix,
  output logic                               out_clipped
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_SIZE  = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_LOOK  = 7'b0100000,
    S_SEND  = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [irf_pkg::RadixW-1:0]      alpha_len_r;
  logic                            signed_r, neg_r, clip_r, err_r;
  logic [irf_pkg::FieldW-1:0]      least_r, most_r;
  logic [irf_pkg::RadixW-1:0]      radix_r;
  logic [irf_pkg::CountW-1:0]      cnt_r;
  logic [irf_pkg::DbufAw-1:0]      idx_r;

  logic                            out_valid_r;
  logic [irf_pkg::CharW-1:0]       out_char_r;
  logic                            out_last_r, out_bad_r, out_clip_r;

  logic                            in_fire, out_free;
  logic                            is_fmt, bad_radix, neg_in;
  logic [irf_pkg::ValueW-1:0]      magnitude;

  logic                            div_start, div_busy, div_done;
  logic [irf_pkg::ValueW-1:0]      div_dividend, div_quo;
  logic [irf_pkg::RadixW-1:0]      div_divisor;
  logic [irf_pkg::DigitW-1:0]      div_rem;

  logic                            dbuf_we;
  logic [irf_pkg::DigitW-1:0]      dbuf_rdata;
  logic                            sym_we;
  logic [irf_pkg::DigitW-1:0]      sym_raddr;
  logic [irf_pkg::CharW-1:0]       sym_rdata;

  logic [irf_pkg::FieldW-1:0]      cut_cnt, pad_cnt;
  logic                            size_clip;
  logic [irf_pkg::DbufAw-1:0]      size_cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && !err_r;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign is_fmt    = (in_cmd == irf_pkg::CMD_UNSIGNED) || (in_cmd == irf_pkg::CMD_SIGNED);
  assign bad_radix = (in_radix < irf_pkg::FieldW'(irf_pkg::RadixMin))
                  || (in_radix > irf_pkg::FieldW'(irf_pkg::AlphabetSize))
                  || (in_radix > {1'b0, alpha_len_r});
  assign neg_in    = (in_cmd == irf_pkg::CMD_SIGNED) && in_number[irf_pkg::ValueW-1];
  assign magnitude = neg_in ? (~in_number + 1'b1) : in_number;

  // first division starts on acceptance, the rest chain off the quotient
  assign div_start    = (in_fire && is_fmt && !bad_radix)
                     || (div_done && (div_quo != '0));
  assign div_dividend = (state_r == S_IDLE) ? magnitude : div_quo;
  assign div_divisor  = (state_r == S_IDLE) ? in_radix[irf_pkg::RadixW-1:0] : radix_r;

  irf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // digits land least significant first; only the low MaxDigits are kept
  assign dbuf_we = div_done && (cnt_r < irf_pkg::CountW'(irf_pkg::MaxDigits));

  irf_ram #(
    .Width (irf_pkg::DigitW),
    .Depth (irf_pkg::MaxDigits)
  ) u_dbuf (
    .clk   (clk),
    .we    (dbuf_we),
    .waddr (cnt_r[irf_pkg::DbufAw-1:0]),
    .wdata (div_rem),
    .raddr (idx_r),
    .rdata (dbuf_rdata)
  );

  assign sym_we = in_fire && (in_cmd == irf_pkg::CMD_LOAD);
  // positions above the natural count are padding with symbol zero
  assign sym_raddr = ({1'b0, idx_r} >= cnt_r) ? '0 : dbuf_rdata;

  irf_ram #(
    .Width (irf_pkg::CharW),
    .Depth (irf_pkg::AlphabetSize)
  ) u_sym (
    .clk   (clk),
    .we    (sym_we),
    .waddr (in_symbol_index),
    .wdata (in_symbol_char),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  // final digit count: cut to the maximum, pad to the minimum, saturate
  always_comb begin
    cut_cnt = {1'b0, cnt_r};
    if ((most_r != '0) && (cut_cnt > most_r)) begin
      cut_cnt = most_r;
    end
    pad_cnt   = (cut_cnt < least_r) ? least_r : cut_cnt;
    size_clip = pad_cnt > irf_pkg::FieldW'(irf_pkg::MaxDigits);
    size_cnt  = size_clip ? irf_pkg::DbufAw'(irf_pkg::MaxDigits) : pad_cnt[irf_pkg::DbufAw-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && is_fmt && !bad_radix) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done && (div_quo == '0)) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        state_nxt = signed_r ? S_SIGN : S_FETCH;
      end
      S_SIGN: begin
        if (out_free) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          state_nxt = (idx_r == '0) ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_len_r <= '0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        alpha_len_r <= cfg_alphabet_length;
      end
      if (in_fire && is_fmt) begin
        err_r <= bad_radix;
        cnt_r <= '0;
      end else if (div_done) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (err_r && out_free) begin
        err_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else if ((state_r == S_SIGN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == S_SEND) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_fmt) begin
      signed_r <= (in_cmd == irf_pkg::CMD_SIGNED);
      neg_r    <= neg_in;
      least_r  <= in_least_digits;
      most_r   <= in_most_digits;
      radix_r  <= in_radix[irf_pkg::RadixW-1:0];
    end
    if (state_r == S_SIZE) begin
      clip_r <= size_clip;
      idx_r  <= size_cnt - 1'b1;
    end else if ((state_r == S_SEND) && out_free) begin
      idx_r <= idx_r - 1'b1;
    end

    if (err_r && out_free) begin
      out_char_r <= irf_pkg::CHAR_NONE;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
      out_clip_r <= 1'b0;
    end else if ((state_r == S_SIGN) && out_free) begin
      out_char_r <= neg_r ? irf_pkg::CHAR_MINUS : irf_pkg::CHAR_PLUS;
      out_last_r <= 1'b0;
      out_bad_r  <= 1'b0;
      out_clip_r <= clip_r;
    end else if ((state_r == S_SEND) && out_free) begin
      out_char_r <= sym_rdata;
      out_last_r <= (idx_r == '0);
      out_bad_r  <= 1'b0;
      out_clip_r <= clip_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_is_last   = out_last_r;
  assign out_bad_radix = out_bad_r;
  assign out_clipped   = out_clip_r;

  `IRF_ASSERT_NOW(a_bad_is_last, out_valid && out_bad_radix, out_is_last && (out_char == irf_pkg::CHAR_NONE), "error transaction must be a lone last character")
  `IRF_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_busy && !div_done, "divider active while taking a new transaction")
  `IRF_ASSERT_NOW(a_done_in_div, div_done, state_r == S_DIV, "divider finished outside the division phase")
  `IRF_ASSERT_NEXT(a_size_clip, state_r == S_SIZE, clip_r == (idx_r == irf_pkg::DbufAw'(irf_pkg::MaxDigits - 1)) || !clip_r, "clipped count must sit at the maximum")

endmodule
